// ===== rtl/core/round_robin_time_slice_scheduler_defines.svh =====
// assertion macros for the round-robin time-slice scheduler
// no dependencies; included by the top level

`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define RRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/rrts_pkg.sv =====
// types and constants of the round-robin time-slice scheduler
// no dependencies

`timescale 1ns / 1ps

package rrts_pkg;

    localparam int JOB_SLOTS_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int TIME8_W = 8;
    localparam int TIME_W  = 16;

    localparam logic [TIME8_W-1:0] QUANTUM_RST = 8'd2;
    localparam logic [TIME_W-1:0]  TIME_MAX    = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [TIME8_W-1:0] arrival;
        logic [TIME8_W-1:0] burst;
        logic [TIME8_W-1:0] remaining;
    } t_job;

endpackage

// ===== rtl/core/round_robin_time_slice_scheduler.sv =====
// A step with nothing pending goes straight to S_FIN; otherwise it scans the slots cyclically from
// the one after the last served slot, then runs S_EXEC and S_FIN (an idle tick scans every slot).
// Throughput: one item at a time; the job memory read port scans one slot per cycle.
// Load, clear and unused commands return nothing.
// Synchronous reset clears the slot flags, clock, counters and sets the quantum to 2;
// the job memory itself is not cleared.
// depends on rrts_pkg and round_robin_time_slice_scheduler_defines.svh

`timescale 1ns / 1ps

`include "round_robin_time_slice_scheduler_defines.svh"

module round_robin_time_slice_scheduler #(
    parameter int JOB_SLOTS = rrts_pkg::JOB_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rrts_pkg::TIME8_W-1:0] i_cfg_time_quantum,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rrts_pkg::CMD_W-1:0]   i_command,
    input  logic [rrts_pkg::IDX_W-1:0]   i_job_index,
    input  logic [rrts_pkg::TIME8_W-1:0] i_arrival_time,
    input  logic [rrts_pkg::TIME8_W-1:0] i_burst_length,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rrts_pkg::IDX_W-1:0]   o_served_job,
    output logic [rrts_pkg::TIME_W-1:0]  o_slice_end_time,
    output logic [rrts_pkg::TIME8_W-1:0] o_run_length,
    output logic                         o_job_finished,
    output logic [rrts_pkg::TIME_W-1:0]  o_turnaround,
    output logic [rrts_pkg::TIME_W-1:0]  o_waiting,
    output logic                         o_idle_tick,
    output logic                         o_all_done,
    output logic [rrts_pkg::TIME_W-1:0]  o_dispatch_count
);

    import rrts_pkg::*;

    localparam int SW = $clog2(JOB_SLOTS);
    localparam int CW = $clog2(JOB_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(JOB_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT  = CW'(JOB_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_FIN
    } t_state;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    t_state               r_state;
    logic [TIME8_W-1:0]   r_quantum;
    logic [JOB_SLOTS-1:0] r_loaded;
    logic [JOB_SLOTS-1:0] r_done;
    logic [CW-1:0]        r_pend;
    logic [TIME_W-1:0]    r_clock;
    logic [SW-1:0]        r_next_slot;
    logic [TIME_W-1:0]    r_slices;

    logic [SW-1:0]        r_rd_slot;
    logic [SW-1:0]        r_chk_slot;
    logic                 r_chk_vld;
    logic [CW-1:0]        r_issued;

    t_job                 r_job;
    logic [SW-1:0]        r_sel;
    logic [TIME8_W-1:0]   r_run;
    logic                 r_fin;
    logic                 r_res_idle;

    logic                 r_out_valid;

    // job memory, one synchronous read port
    t_job                 mem_job [JOB_SLOTS];
    t_job                 r_rd_data;
    logic                 mem_we;
    logic [SW-1:0]        mem_waddr;
    t_job                 mem_wdata;

    logic                 in_acc;
    logic                 loadable;
    logic [SW-1:0]        ld_slot;
    logic                 cand;
    logic [TIME8_W-1:0]   quantum_eff;
    logic [TIME8_W-1:0]   run_len;
    logic [TIME8_W-1:0]   rem_new;
    logic [TIME_W:0]      clock_sum;
    logic [TIME_W-1:0]    clock_new;
    logic [TIME_W-1:0]    tat;
    logic [TIME_W-1:0]    wait_t;
    logic                 out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign loadable = (32'(i_job_index) < JOB_SLOTS);
    assign ld_slot  = SW'(i_job_index);

    assign cand = r_chk_vld && r_loaded[r_chk_slot] && !r_done[r_chk_slot]
                  && ({8'd0, r_rd_data.arrival} <= r_clock);

    assign quantum_eff = (r_quantum == '0) ? 8'd1 : r_quantum;
    assign run_len     = (r_job.remaining < quantum_eff) ? r_job.remaining : quantum_eff;
    assign rem_new     = r_job.remaining - run_len;
    assign clock_sum   = {1'b0, r_clock} + {9'd0, run_len};
    assign clock_new   = clock_sum[TIME_W] ? TIME_MAX : clock_sum[TIME_W-1:0];

    assign tat    = r_fin ? (r_clock - {8'd0, r_job.arrival}) : '0;
    assign wait_t = (tat > {8'd0, r_job.burst}) ? (tat - {8'd0, r_job.burst}) : '0;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sel;
        mem_wdata = '{arrival: r_job.arrival, burst: r_job.burst, remaining: rem_new};
        if (r_state == S_IDLE && in_acc && i_command == CMD_LOAD && loadable) begin
            mem_we    = 1'b1;
            mem_waddr = ld_slot;
            mem_wdata = '{arrival: i_arrival_time, burst: i_burst_length,
                          remaining: i_burst_length};
        end else if (r_state == S_EXEC) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_job[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem_job[r_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QUANTUM_RST;
            r_loaded    <= '0;
            r_done      <= '0;
            r_pend      <= '0;
            r_clock     <= '0;
            r_next_slot <= '0;
            r_slices    <= '0;
            r_rd_slot   <= '0;
            r_chk_slot  <= '0;
            r_chk_vld   <= 1'b0;
            r_issued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_time_quantum;
            end
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_command)
                            CMD_LOAD: begin
                                if (loadable) begin
                                    if (!(r_loaded[ld_slot] && !r_done[ld_slot])) begin
                                        r_pend <= r_pend + 1'b1;
                                    end
                                    r_loaded[ld_slot] <= 1'b1;
                                    r_done[ld_slot]   <= 1'b0;
                                end
                            end
                            CMD_STEP: begin
                                r_sel      <= '0;
                                r_run      <= '0;
                                r_fin      <= 1'b0;
                                r_res_idle <= 1'b0;
                                if (r_pend == '0) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_rd_slot <= r_next_slot;
                                    r_chk_vld <= 1'b0;
                                    r_issued  <= '0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_loaded    <= '0;
                                r_done      <= '0;
                                r_pend      <= '0;
                                r_clock     <= '0;
                                r_next_slot <= '0;
                                r_slices    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_chk_slot <= r_rd_slot;
                    r_chk_vld  <= (r_issued != SLOT_CNT);
                    r_rd_slot  <= slot_inc(r_rd_slot);
                    if (r_issued != SLOT_CNT) begin
                        r_issued <= r_issued + 1'b1;
                    end
                    if (cand) begin
                        r_job   <= r_rd_data;
                        r_sel   <= r_chk_slot;
                        r_state <= S_EXEC;
                    end else if (!r_chk_vld && r_issued == SLOT_CNT) begin
                        r_res_idle <= 1'b1;
                        if (r_clock != TIME_MAX) begin
                            r_clock <= r_clock + 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_EXEC: begin
                    r_clock     <= clock_new;
                    r_run       <= run_len;
                    r_next_slot <= slot_inc(r_sel);
                    if (r_slices != TIME_MAX) begin
                        r_slices <= r_slices + 1'b1;
                    end
                    if (rem_new == '0) begin
                        r_fin         <= 1'b1;
                        r_done[r_sel] <= 1'b1;
                        r_pend        <= r_pend - 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        o_served_job     <= IDX_W'(r_sel);
                        o_slice_end_time <= r_clock;
                        o_run_length     <= r_run;
                        o_job_finished   <= r_fin;
                        o_turnaround     <= tat;
                        o_waiting        <= wait_t;
                        o_idle_tick      <= r_res_idle;
                        o_all_done       <= (r_pend == '0);
                        o_dispatch_count <= r_slices;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // dispatched slot must be a live job
    `RRTS_ASSERT_IMPL(a_exec_live, i_clk, i_rst_n, r_state == S_EXEC, r_loaded[r_sel] && !r_done[r_sel])
    // an idle tick only happens while jobs are pending
    `RRTS_ASSERT_IMPL(a_idle_pending, i_clk, i_rst_n, r_state == S_FIN && r_res_idle, r_pend != '0)
    // a step with pending jobs starts a scan
    `RRTS_ASSERT_NEXT(a_step_scan, i_clk, i_rst_n, in_acc && i_command == CMD_STEP && r_pend != '0, r_state == S_SCAN)
    // pending count never exceeds the table
    `RRTS_ASSERT_IMPL(a_pend_range, i_clk, i_rst_n, 1'b1, r_pend <= SLOT_CNT)

endmodule

// ===== bench/tb_round_robin_time_slice_scheduler.sv =====
// self-checking testbench for round_robin_time_slice_scheduler: directed table, random
// job mixes under several quanta, and a clock saturation soak
// depends on rrts_pkg and the scheduler rtl

`timescale 1ns / 1ps

module tb_round_robin_time_slice_scheduler;
    import rrts_pkg::*;

    localparam int JOB_SLOTS    = JOB_SLOTS_DEF;
    localparam int SETTLE_CYCLES = JOB_SLOTS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int SOAK_ROUNDS  = 17;
    localparam int MIX_ITEMS    = 35;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]   served;
        logic [TIME_W-1:0]  end_time;
        logic [TIME8_W-1:0] run_len;
        logic               finished;
        logic [TIME_W-1:0]  tat;
        logic [TIME_W-1:0]  wait_time;
        logic               idle;
        logic               all_done;
        logic [TIME_W-1:0]  count;
    } t_slice;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [TIME8_W-1:0] arr;
        logic [TIME8_W-1:0] burst;
        bit                 pin;
        t_slice             res;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TIME8_W-1:0]   i_cfg_time_quantum;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command;
    logic [IDX_W-1:0]     i_job_index;
    logic [TIME8_W-1:0]   i_arrival_time;
    logic [TIME8_W-1:0]   i_burst_length;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [IDX_W-1:0]     o_served_job;
    logic [TIME_W-1:0]    o_slice_end_time;
    logic [TIME8_W-1:0]   o_run_length;
    logic                 o_job_finished;
    logic [TIME_W-1:0]    o_turnaround;
    logic [TIME_W-1:0]    o_waiting;
    logic                 o_idle_tick;
    logic                 o_all_done;
    logic [TIME_W-1:0]    o_dispatch_count;

    // scheduler state as predicted
    int unsigned          sched_quantum;
    bit                   sched_loaded [JOB_SLOTS];
    bit                   sched_done [JOB_SLOTS];
    logic [TIME8_W-1:0]   sched_arr [JOB_SLOTS];
    logic [TIME8_W-1:0]   sched_bur [JOB_SLOTS];
    logic [TIME8_W-1:0]   sched_rem [JOB_SLOTS];
    int unsigned          sched_clock;
    int unsigned          sched_next;
    int unsigned          sched_slices;

    t_slice               slice_q[$];
    t_stim_row            dir_rows[$];
    t_slice               pred_res;
    t_slice               want_slice;
    bit                   pred_has;
    bit                   drv_pinned;
    t_slice               drv_pinned_res;
    bit                   tx_quiet;
    bit                   rx_quiet;
    bit                   hold_req;
    int unsigned          cur_quantum;
    int unsigned          n_errors;
    int unsigned          n_items;
    int unsigned          n_slices;
    int unsigned          n_idle;
    int unsigned          n_finished;
    int unsigned          n_cfg;
    int unsigned          stuck_cycles;

    round_robin_time_slice_scheduler u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_time_quantum (i_cfg_time_quantum),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_job_index        (i_job_index),
        .i_arrival_time     (i_arrival_time),
        .i_burst_length     (i_burst_length),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_served_job       (o_served_job),
        .o_slice_end_time   (o_slice_end_time),
        .o_run_length       (o_run_length),
        .o_job_finished     (o_job_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_idle_tick        (o_idle_tick),
        .o_all_done         (o_all_done),
        .o_dispatch_count   (o_dispatch_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_schedule();
        for (int k = 0; k < JOB_SLOTS; k++) begin
            sched_loaded[k] = 0;
            sched_done[k]   = 0;
            sched_arr[k]    = '0;
            sched_bur[k]    = '0;
            sched_rem[k]    = '0;
        end
        sched_clock  = 0;
        sched_next   = 0;
        sched_slices = 0;
    endfunction

    function automatic bit jobs_pending();
        for (int k = 0; k < JOB_SLOTS; k++)
            if (sched_loaded[k] && !sched_done[k])
                return 1;
        return 0;
    endfunction

    function automatic void predict_item(input logic [CMD_W-1:0] cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [TIME8_W-1:0] arr,
                                         input logic [TIME8_W-1:0] burst,
                                         output bit has_res, output t_slice res);
        int unsigned q;
        int unsigned run;
        int unsigned tat;
        int unsigned s;
        bit found;
        res = '0;
        has_res = 0;
        found = 0;
        s = 0;
        if (cmd == CMD_LOAD) begin
            sched_loaded[idx] = 1;
            sched_arr[idx]    = arr;
            sched_bur[idx]    = burst;
            sched_rem[idx]    = burst;
            sched_done[idx]   = 0;
        end else if (cmd == CMD_CLEAR) begin
            clear_schedule();
        end else if (cmd == CMD_STEP) begin
            has_res = 1;
            if (jobs_pending()) begin
                for (int k = 0; k < JOB_SLOTS && !found; k++) begin
                    s = (sched_next + k) % JOB_SLOTS;
                    if (sched_loaded[s] && !sched_done[s] && sched_arr[s] <= sched_clock)
                        found = 1;
                end
                if (found) begin
                    q = (sched_quantum == 0) ? 1 : sched_quantum;
                    run = (sched_rem[s] < q) ? 32'(sched_rem[s]) : q;
                    sched_clock = (sched_clock + run > TIME_MAX) ? 32'(TIME_MAX)
                                                                 : sched_clock + run;
                    sched_rem[s] = TIME8_W'(32'(sched_rem[s]) - run);
                    if (sched_slices < TIME_MAX)
                        sched_slices++;
                    sched_next = (s + 1) % JOB_SLOTS;
                    res.served  = IDX_W'(s);
                    res.run_len = TIME8_W'(run);
                    if (sched_rem[s] == 0) begin
                        sched_done[s] = 1;
                        res.finished  = 1'b1;
                        tat = sched_clock - 32'(sched_arr[s]);
                        res.tat = TIME_W'(tat);
                        res.wait_time = (tat > sched_bur[s]) ? TIME_W'(tat - sched_bur[s])
                                                              : '0;
                    end
                end else begin
                    res.idle = 1'b1;
                    if (sched_clock < TIME_MAX)
                        sched_clock++;
                end
            end
            res.end_time = TIME_W'(sched_clock);
            res.all_done = !jobs_pending();
            res.count    = TIME_W'(sched_slices);
        end
    endfunction

    function automatic t_slice mk_slice(int unsigned served, int unsigned end_time,
                                        int unsigned run_len, bit finished, int unsigned tat,
                                        int unsigned wait_time, bit idle, bit all_done,
                                        int unsigned count);
        t_slice r;
        r.served    = IDX_W'(served);
        r.end_time  = TIME_W'(end_time);
        r.run_len   = TIME8_W'(run_len);
        r.finished  = finished;
        r.tat       = TIME_W'(tat);
        r.wait_time = TIME_W'(wait_time);
        r.idle      = idle;
        r.all_done  = all_done;
        r.count     = TIME_W'(count);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // scoreboard: results first, then new items into the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (slice_q.size() == 0) begin
                    $error("result with nothing expected: served_job %0d", o_served_job);
                    n_errors++;
                end else begin
                    want_slice = slice_q.pop_front();
                    check_field("served_job", 32'(want_slice.served), 32'(o_served_job));
                    check_field("slice_end_time", 32'(want_slice.end_time),
                                32'(o_slice_end_time));
                    check_field("run_length", 32'(want_slice.run_len), 32'(o_run_length));
                    check_field("job_finished", 32'(want_slice.finished),
                                32'(o_job_finished));
                    check_field("turnaround", 32'(want_slice.tat), 32'(o_turnaround));
                    check_field("waiting", 32'(want_slice.wait_time), 32'(o_waiting));
                    check_field("idle_tick", 32'(want_slice.idle), 32'(o_idle_tick));
                    check_field("all_done", 32'(want_slice.all_done), 32'(o_all_done));
                    check_field("dispatch_count", 32'(want_slice.count),
                                32'(o_dispatch_count));
                    n_slices++;
                    n_idle     += 32'(want_slice.idle);
                    n_finished += 32'(want_slice.finished);
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_item(i_command, i_job_index, i_arrival_time, i_burst_length,
                             pred_has, pred_res);
                if (pred_has)
                    slice_q.insert(slice_q.size(), drv_pinned ? drv_pinned_res : pred_res);
                n_items++;
            end
            if (i_cfg_valid && o_cfg_ready)
                sched_quantum = 32'(i_cfg_time_quantum);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles == STALL_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
                $display("round_robin_time_slice_scheduler regression: fail");
                $finish;
            end
        end
    end

    // result side: random stall per item, one long hold-off on request
    initial begin
        int unsigned rx_gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 10);
            if (rx_gap != 0) begin
                i_out_ready = 0;
                repeat (rx_gap) @(negedge i_clk);
            end
            i_out_ready = 1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [TIME8_W-1:0] arr, input logic [TIME8_W-1:0] burst,
                             input bit pin, input t_slice pin_res);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_command      = cmd;
        i_job_index    = idx;
        i_arrival_time = arr;
        i_burst_length = burst;
        drv_pinned     = pin;
        drv_pinned_res = pin_res;
        i_in_valid     = 1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                        input logic [TIME8_W-1:0] arr, input logic [TIME8_W-1:0] burst);
        send_item(cmd, idx, arr, burst, 0, '0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 0;
        while (slice_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_quantum(input logic [TIME8_W-1:0] q);
        drain_results();
        @(negedge i_clk);
        i_cfg_time_quantum = q;
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
        cur_quantum = 32'(q);
        n_cfg++;
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [TIME8_W-1:0] arr, input logic [TIME8_W-1:0] burst,
                           input bit pin, input t_slice res);
        t_stim_row row;
        row.cmd   = cmd;
        row.idx   = idx;
        row.arr   = arr;
        row.burst = burst;
        row.pin   = pin;
        row.res   = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // job mixes: mostly load-then-step sequences, some raw noise
    task automatic run_mix(input int unsigned n);
        int unsigned done_items;
        int unsigned need;
        int unsigned steps;
        int unsigned qeff;
        logic [CMD_W-1:0] cmd;
        logic [TIME8_W-1:0] a;
        logic [TIME8_W-1:0] b;
        done_items = 0;
        while (done_items < n) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 2) == 0) begin
                    send(CMD_CLEAR, IDX_W'($urandom), TIME8_W'($urandom), TIME8_W'($urandom));
                    done_items++;
                end
                qeff = (cur_quantum == 0) ? 1 : cur_quantum;
                need = 0;
                repeat ($urandom_range(1, 6)) begin
                    a = ($urandom_range(0, 3) == 0) ? TIME8_W'($urandom_range(0, 255))
                                                    : TIME8_W'($urandom_range(0, 30));
                    b = ($urandom_range(0, 4) == 0) ? TIME8_W'($urandom_range(0, 255))
                                                    : TIME8_W'($urandom_range(0, 12));
                    send(CMD_LOAD, IDX_W'($urandom_range(0, JOB_SLOTS - 1)), a, b);
                    need += (b == 0) ? 1 : (32'(b) + qeff - 1) / qeff;
                    done_items++;
                end
                steps = need + $urandom_range(0, 4);
                if (steps > 40)
                    steps = 40;
                repeat (steps) begin
                    if ($urandom_range(0, 11) == 0)
                        send(CMD_LOAD, IDX_W'($urandom), TIME8_W'($urandom_range(0, 40)),
                             TIME8_W'($urandom_range(0, 12)));
                    else
                        send(CMD_STEP, IDX_W'($urandom), TIME8_W'($urandom),
                             TIME8_W'($urandom));
                    done_items++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    send(cmd, IDX_W'($urandom), TIME8_W'($urandom), TIME8_W'($urandom));
                    if (cmd != CMD_UNUSED)
                        done_items++;
                end
            end
        end
    endtask

    initial begin
        int unsigned qlist [7];
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_time_quantum = '0;
        i_in_valid = 0;
        i_command = CMD_LOAD;
        i_job_index = '0;
        i_arrival_time = '0;
        i_burst_length = '0;
        i_out_ready = 0;
        drv_pinned = 0;
        drv_pinned_res = '0;
        tx_quiet = 0;
        rx_quiet = 0;
        hold_req = 0;
        n_errors = 0;
        n_items = 0;
        n_slices = 0;
        n_idle = 0;
        n_finished = 0;
        n_cfg = 0;
        stuck_cycles = 0;
        sched_quantum = 32'(QUANTUM_RST);
        cur_quantum = 32'(QUANTUM_RST);
        clear_schedule();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // empty table, unused code, zero burst, idle tick, clear, overwrite
        add_row(CMD_STEP, 0, 0, 0, 1, mk_slice(0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(CMD_UNUSED, 5, 9, 9, 0, '0);
        add_row(CMD_STEP, 0, 0, 0, 1, mk_slice(0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(CMD_LOAD, 0, 0, 0, 0, '0);
        add_row(CMD_STEP, 0, 0, 0, 1, mk_slice(0, 0, 0, 1, 0, 0, 0, 1, 1));
        add_row(CMD_LOAD, 15, 255, 255, 0, '0);
        add_row(CMD_STEP, 0, 0, 0, 1, mk_slice(0, 1, 0, 0, 0, 0, 1, 0, 1));
        add_row(CMD_CLEAR, 15, 255, 255, 0, '0);
        add_row(CMD_STEP, 15, 255, 255, 1, mk_slice(0, 0, 0, 0, 0, 0, 0, 1, 0));
        add_row(CMD_LOAD, 3, 0, 5, 0, '0);
        add_row(CMD_LOAD, 7, 1, 3, 0, '0);
        add_row(CMD_LOAD, 12, 10, 1, 0, '0);
        add_row(CMD_LOAD, 9, 0, 2, 0, '0);
        add_row(CMD_LOAD, 9, 0, 1, 0, '0);
        for (int k = 0; k < 9; k++)
            add_row(CMD_STEP, 0, 0, 0, 0, '0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, '0);
        foreach (dir_rows[k])
            send_item(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].arr, dir_rows[k].burst,
                      dir_rows[k].pin, dir_rows[k].res);

        qlist = '{1, 255, 0, $urandom_range(3, 20), 128, $urandom_range(1, 255), 2};
        for (int p = 0; p < 7; p++) begin
            set_quantum(TIME8_W'(qlist[p]));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                tx_quiet = 0;
                rx_quiet = 0;
                hold_req = 1;
            end
            run_mix(MIX_ITEMS);
        end

        // full-quantum slices drive the clock into saturation, no idling on either side
        set_quantum(8'd255);
        tx_quiet = 1;
        rx_quiet = 1;
        send(CMD_CLEAR, '0, '0, '0);
        repeat (SOAK_ROUNDS) begin
            for (int k = 0; k < JOB_SLOTS; k++)
                send(CMD_LOAD, IDX_W'(k), 8'd0, 8'd255);
            repeat (JOB_SLOTS)
                send(CMD_STEP, '0, '0, '0);
        end
        drain_results();

        $display("%0d items driven, %0d slices checked (%0d idle ticks, %0d completions)",
                 n_items, n_slices, n_idle, n_finished);
        $display("%0d quantum writes incl. 0 and 255, long output hold-off, clock saturation",
                 n_cfg);
        if (n_errors == 0) begin
            $display("round_robin_time_slice_scheduler regression: pass");
        end else begin
            $display("round_robin_time_slice_scheduler regression: fail");
        end
        $finish;
    end

endmodule
